FILE: design/okl_pkg.sv
// Shared constants, types and elaboration-time table builders for the Oklab distance core.
`default_nettype none

package okl_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int LINEAR_BITS_DEF = 18;

    // Q30 cube root: one trial-square stage and one trial-cube stage per result bit
    localparam int CBRT_BITS   = 30;
    localparam int CBRT_STAGES = 2 * CBRT_BITS;

    localparam int LIN_MAX_W = 25;
    localparam int LMS_C_W   = 31;
    localparam int LAB_C_W   = 34;
    localparam int DIST_W    = 17;

    localparam logic [DIST_W-1:0] DIST_MAX = 17'd131071;
    localparam logic [30:0]       ONE30    = 31'h4000_0000;

    typedef logic [LIN_MAX_W-1:0] lin_table_t [256];

    // Round a ten-digit decimal fraction to Q30, half up
    function automatic logic [63:0] q30(input logic [63:0] d);
        return (d * 64'd2097152 + 64'd9765625) / 64'd19531250;
    endfunction

    function automatic logic [63:0] m30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + 64'h2000_0000) >> 30;
    endfunction

    function automatic logic [63:0] pow5_30(input logic [63:0] y);
        logic [63:0] y2;
        y2 = m30(y, y);
        return m30(m30(y2, y2), y);
    endfunction

    // sRGB decode table, x^2.4 through an exact fixed-point fifth root
    function automatic lin_table_t lin_table_build(input int lbits);
        lin_table_t  tbl;
        logic [63:0] n;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        for (int c = 0; c < 256; c++) begin
            if (c <= 10) begin
                tbl[c] = LIN_MAX_W'(((64'(c) * 64'd200 << lbits) + 64'd329460) / 64'd658920);
            end else begin
                n  = 64'd1000 * 64'(c) + 64'd14025;
                x  = ((n << 31) + 64'd269025) / 64'd538050;
                x2 = m30(x, x);
                lo = 64'd0;
                hi = 64'h4000_0000;
                for (int k = 0; k < 40; k++) begin
                    if (lo < hi) begin
                        mid = lo + (hi - lo + 64'd1) / 64'd2;
                        if (pow5_30(mid) <= x2) begin
                            lo = mid;
                        end else begin
                            hi = mid - 64'd1;
                        end
                    end
                end
                p      = m30(x2, lo);
                tbl[c] = LIN_MAX_W'((p + (64'd1 << (29 - lbits))) >> (30 - lbits));
            end
        end
        return tbl;
    endfunction

    localparam logic [LMS_C_W-1:0] LMS_COEF [9] = '{
        LMS_C_W'(q30(64'd4122214708)), LMS_C_W'(q30(64'd5363325363)),
        LMS_C_W'(q30(64'd514459929)),
        LMS_C_W'(q30(64'd2119034982)), LMS_C_W'(q30(64'd6806995451)),
        LMS_C_W'(q30(64'd1073969566)),
        LMS_C_W'(q30(64'd883024619)),  LMS_C_W'(q30(64'd2817188376)),
        LMS_C_W'(q30(64'd6299787005))
    };

    localparam logic signed [LAB_C_W-1:0] LAB_COEF [9] = '{
        $signed(LAB_C_W'(q30(64'd2104542553))),
        $signed(LAB_C_W'(q30(64'd7936177850))),
        -$signed(LAB_C_W'(q30(64'd40720468))),
        $signed(LAB_C_W'(q30(64'd19779984951))),
        -$signed(LAB_C_W'(q30(64'd24285922050))),
        $signed(LAB_C_W'(q30(64'd4505937099))),
        $signed(LAB_C_W'(q30(64'd259040371))),
        $signed(LAB_C_W'(q30(64'd7827717662))),
        -$signed(LAB_C_W'(q30(64'd8086757660)))
    };

endpackage

`default_nettype wire

FILE: design/okl_cbrt.sv
// Pipelined Q30 cube root: largest y with round(round(y*y)*y) <= v, one bit per two stages.
`default_nettype none

module okl_cbrt
    import okl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [30:0] v,
    output logic      [30:0] y
);

    logic [CBRT_BITS-1:0] a_y_reg    [CBRT_BITS];
    logic [30:0]          a_sq_reg   [CBRT_BITS];
    logic [CBRT_BITS-1:0] a_v_reg    [CBRT_BITS];
    logic                 a_full_reg [CBRT_BITS];
    logic [CBRT_BITS-1:0] b_y_reg    [CBRT_BITS];
    logic [CBRT_BITS-1:0] b_v_reg    [CBRT_BITS];
    logic                 b_full_reg [CBRT_BITS];

    for (genvar k = 0; k < CBRT_BITS; k++) begin : g_bit
        localparam int BIT = CBRT_BITS - 1 - k;

        logic [CBRT_BITS-1:0] y_prev;
        logic [CBRT_BITS-1:0] v_prev;
        logic                 full_prev;
        logic [CBRT_BITS-1:0] t_a;
        logic [59:0]          tt;
        logic [30:0]          sq_next;
        logic [CBRT_BITS-1:0] t_b;
        logic [60:0]          ct;
        logic [30:0]          cube;
        logic [CBRT_BITS-1:0] y_next;

        if (k == 0) begin : g_first
            assign y_prev    = '0;
            assign v_prev    = v[CBRT_BITS-1:0];
            assign full_prev = v[30];
        end else begin : g_rest
            assign y_prev    = b_y_reg[k-1];
            assign v_prev    = b_v_reg[k-1];
            assign full_prev = b_full_reg[k-1];
        end

        // trial square
        always_comb
        begin
            t_a     = y_prev | (CBRT_BITS'(1) << BIT);
            tt      = 60'(t_a) * 60'(t_a);
            sq_next = 31'((tt + 60'h2000_0000) >> 30);
        end

        // trial cube, keep the bit if it does not overshoot
        always_comb
        begin
            t_b    = a_y_reg[k] | (CBRT_BITS'(1) << BIT);
            ct     = 61'(a_sq_reg[k]) * 61'(t_b);
            cube   = 31'((ct + 61'h2000_0000) >> 30);
            y_next = (cube <= {1'b0, a_v_reg[k]}) ? t_b : a_y_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_y_reg[k]    <= y_prev;
                a_sq_reg[k]   <= sq_next;
                a_v_reg[k]    <= v_prev;
                a_full_reg[k] <= full_prev;
                b_y_reg[k]    <= y_next;
                b_v_reg[k]    <= a_v_reg[k];
                b_full_reg[k] <= a_full_reg[k];
            end
        end
    end

    assign y = b_full_reg[CBRT_BITS-1] ? ONE30 : {1'b0, b_y_reg[CBRT_BITS-1]};

endmodule

`default_nettype wire

FILE: design/okl_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module okl_isqrt
    import okl_pkg::*;
#(
    parameter int SQ_W = 2 * (FRAC_BITS_DEF + 3) + 2
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_vld,
    input  wire logic [SQ_W-1:0]           radicand,
    output logic                           out_vld,
    output logic      [(SQ_W+1)/2-1:0]     root
);

    localparam int RT_W = (SQ_W + 1) / 2;
    localparam int W2   = 2 * RT_W + 1;

    logic [W2-1:0]   rem_reg [RT_W];
    logic [RT_W-1:0] res_reg [RT_W];
    logic            vld_reg [RT_W];

    for (genvar k = 0; k < RT_W; k++) begin : g_bit
        localparam int BIT = RT_W - 1 - k;

        logic [W2-1:0]   rem_prev;
        logic [RT_W-1:0] res_prev;
        logic            vld_prev;
        logic [W2-1:0]   trial;
        logic [W2-1:0]   rem_next;
        logic [RT_W-1:0] res_next;

        if (k == 0) begin : g_first
            assign rem_prev = W2'(radicand);
            assign res_prev = '0;
            assign vld_prev = in_vld;
        end else begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign res_prev = res_reg[k-1];
            assign vld_prev = vld_reg[k-1];
        end

        always_comb
        begin
            trial = (W2'(res_prev) << (BIT + 1)) + (W2'(1) << (2 * BIT));
            if (rem_prev >= trial)
            begin
                rem_next = rem_prev - trial;
                res_next = res_prev | (RT_W'(1) << BIT);
            end
            else
            begin
                rem_next = rem_prev;
                res_next = res_prev;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                res_reg[k] <= res_next;
            end
        end
    end

    assign out_vld = vld_reg[RT_W-1];
    assign root    = res_reg[RT_W-1];

endmodule

`default_nettype wire

FILE: design/srgb_oklab_color_distance_core.sv
// Pipeline from a pair transfer to its distance: 3 decode/LMS stages, 60 cube-root stages,
//   6 Oklab/square stages, FRAC_BITS + 4 square-root stages, one output register.
// Throughput: one color pair per cycle while pair_stall is low; a stalled result parks in a skid register,
//   and pair_stall rises only while that skid register is full.
// Reset: rst_n clears all valid bits, including the output and skid valid flags; data is not reset.
`default_nettype none

module srgb_oklab_color_distance_core
    import okl_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int LINEAR_BITS = LINEAR_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                pair_valid,
    output logic                     pair_stall,
    input  wire logic [23:0]         first_rgb,
    input  wire logic [23:0]         second_rgb,
    output logic                     dist_valid,
    input  wire logic                dist_stall,
    output logic      [DIST_W-1:0]   distance
);

    localparam int LIN_W = LINEAR_BITS + 1;
    localparam int LP_W  = LMS_C_W + LIN_W;
    localparam int LS_W  = LP_W + 2;
    localparam int VR_W  = LS_W - LINEAR_BITS;
    localparam int LABP_W = 66;
    localparam int LABS_W = 68;
    localparam int QW    = FRAC_BITS + 3;
    localparam int SQW   = 2 * QW + 2;
    localparam int RT_W  = (SQW + 1) / 2;
    localparam int EW    = (RT_W > DIST_W) ? RT_W : DIST_W;

    localparam lin_table_t LIN_TABLE = lin_table_build(LINEAR_BITS);

    logic en;
    logic accept;

    logic                    v1_reg;
    logic [LIN_W-1:0]        lin_reg   [6];
    logic                    v2_reg;
    logic [LP_W-1:0]         lprod_reg [18];
    logic                    v3_reg;
    logic [30:0]             lmsv_reg  [6];
    logic                    cv_reg    [CBRT_STAGES];
    logic [30:0]             cb        [6];
    logic                    v4_reg;
    logic signed [31:0]      diff_reg  [3];
    logic                    v5_reg;
    logic signed [LABP_W-1:0] labp_reg [9];
    logic                    v6_reg;
    logic signed [LABS_W-1:0] labs_reg [3];
    logic                    v7_reg;
    logic [QW-1:0]           q_reg     [3];
    logic                    v8_reg;
    logic [2*QW-1:0]         qsq_reg   [3];
    logic                    v9_reg;
    logic [SQW-1:0]          sumsq_reg;

    logic                    root_vld;
    logic [RT_W-1:0]         root;
    logic [EW-1:0]           root_ext;
    logic [DIST_W-1:0]       dist_sat;
    logic                    arrive;
    logic                    take;

    logic                    out_valid_reg;
    logic [DIST_W-1:0]       out_dist_reg;
    logic                    skid_valid_reg;
    logic [DIST_W-1:0]       skid_dist_reg;

    logic [7:0]              codes [6];

    // Hold the whole pipeline only while the skid register is occupied
    assign en         = !skid_valid_reg;
    assign pair_stall = skid_valid_reg;
    assign accept     = pair_valid && en;

    assign codes[0] = first_rgb[23:16];
    assign codes[1] = first_rgb[15:8];
    assign codes[2] = first_rgb[7:0];
    assign codes[3] = second_rgb[23:16];
    assign codes[4] = second_rgb[15:8];
    assign codes[5] = second_rgb[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            for (int k = 0; k < CBRT_STAGES; k++)
            begin
                cv_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg    <= accept;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            cv_reg[0] <= v3_reg;
            for (int k = 1; k < CBRT_STAGES; k++)
            begin
                cv_reg[k] <= cv_reg[k-1];
            end
            v4_reg <= cv_reg[CBRT_STAGES-1];
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    // Decode and LMS
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 6; c++)
            begin
                lin_reg[c] <= LIN_TABLE[codes[c]][LIN_W-1:0];
            end
            for (int c = 0; c < 2; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        lprod_reg[c*9 + r*3 + k] <= LP_W'(LMS_COEF[r*3 + k]) * LP_W'(lin_reg[c*3 + k]);
                    end
                end
            end
        end
    end

    for (genvar i = 0; i < 6; i++) begin : g_lms
        logic [LS_W-1:0] lsum;
        logic [VR_W-1:0] vr;

        always_comb
        begin
            lsum = LS_W'(lprod_reg[(i/3)*9 + (i%3)*3]) + LS_W'(lprod_reg[(i/3)*9 + (i%3)*3 + 1])
                 + LS_W'(lprod_reg[(i/3)*9 + (i%3)*3 + 2]);
            vr   = VR_W'((lsum + (LS_W'(1) << (LINEAR_BITS - 1))) >> LINEAR_BITS);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lmsv_reg[i] <= (vr > VR_W'(ONE30)) ? ONE30 : vr[30:0];
            end
        end

        okl_cbrt u_cbrt (
            .clk (clk),
            .en  (en),
            .v   (lmsv_reg[i]),
            .y   (cb[i])
        );
    end

    // Oklab differences, squares and sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                diff_reg[r] <= $signed({1'b0, cb[r]}) - $signed({1'b0, cb[r+3]});
            end
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    labp_reg[r*3 + k] <= LABP_W'(LAB_COEF[r*3 + k]) * LABP_W'(diff_reg[k]);
                end
            end
            for (int r = 0; r < 3; r++)
            begin
                labs_reg[r] <= LABS_W'(labp_reg[r*3]) + LABS_W'(labp_reg[r*3 + 1])
                             + LABS_W'(labp_reg[r*3 + 2]);
            end
            for (int r = 0; r < 3; r++)
            begin
                qsq_reg[r] <= (2*QW)'(q_reg[r]) * (2*QW)'(q_reg[r]);
            end
            sumsq_reg <= SQW'(qsq_reg[0]) + SQW'(qsq_reg[1]) + SQW'(qsq_reg[2]);
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_round
        logic [LABS_W-1:0] mag;
        logic [LABS_W-1:0] rnd;

        always_comb
        begin
            mag = labs_reg[r][LABS_W-1] ? LABS_W'(-labs_reg[r]) : LABS_W'(labs_reg[r]);
            rnd = (mag + (LABS_W'(1) << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[r] <= rnd[QW-1:0];
            end
        end
    end

    okl_isqrt #(
        .SQ_W (SQW)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v9_reg),
        .radicand (sumsq_reg),
        .out_vld  (root_vld),
        .root     (root)
    );

    assign root_ext = EW'(root);
    assign dist_sat = (root_ext > EW'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_W-1:0];

    // Output register with skid
    assign arrive = root_vld && en;
    assign take   = out_valid_reg && !dist_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_dist_reg <= skid_dist_reg;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !take)
            begin
                skid_dist_reg <= dist_sat;
            end
            else
            begin
                out_dist_reg <= dist_sat;
            end
        end
    end

    assign dist_valid = out_valid_reg;
    assign distance   = out_dist_reg;

endmodule

`default_nettype wire

FILE: design/okl_chk.sv
// Port-level checks for the Oklab distance core, attached by bind.
`default_nettype none

module okl_chk
    import okl_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              pair_valid,
    input wire logic              pair_stall,
    input wire logic              dist_valid,
    input wire logic              dist_stall,
    input wire logic [DIST_W-1:0] distance
);

    a_dist_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dist_valid && dist_stall |=> dist_valid)
        else $error("result dropped while stalled");

    a_dist_stable: assert property (@(posedge clk) disable iff (!rst_n)
        dist_valid && dist_stall |=> $stable(distance))
        else $error("result changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pair_stall) |-> $past(dist_valid && dist_stall))
        else $error("pair_stall rose without a stalled result");

    a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
        pair_stall |-> dist_valid)
        else $error("pair_stall high with no result on offer");

    a_pair_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && pair_stall |=> pair_valid)
        else $error("pair offer withdrawn while stalled");

endmodule

bind srgb_oklab_color_distance_core okl_chk u_okl_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .dist_valid (dist_valid),
    .dist_stall (dist_stall),
    .distance   (distance)
);

`default_nettype wire
